// ===== rtl/afpd_pkg.sv =====
package afpd_pkg;

   // Fixed configuration field widths
   localparam int RATIO_BITS    = 8;
   localparam int RISE_BITS     = 12;
   localparam int FALL_BITS     = 8;
   localparam int LEN_BITS      = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam int DET_BITS      = 3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_RISE_RATIO     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CONFIRM_LENGTH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_AVERAGE_LENGTH = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_FALL_RATIO     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRESET_FLOOR   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRESET_COUNT   = 3'd5;

   // Register reset values
   localparam logic [RISE_BITS-1:0] RISE_RESET    = 12'd512;
   localparam logic [LEN_BITS-1:0]  CONFIRM_RESET = 16'd4;
   localparam logic [LEN_BITS-1:0]  AVERAGE_RESET = 16'd1024;
   localparam logic [FALL_BITS-1:0] FALL_RESET    = 8'd192;

   // Detection state codes
   localparam logic [DET_BITS-1:0] DET_BELOW   = 3'd0;
   localparam logic [DET_BITS-1:0] DET_ABOVE   = 3'd1;
   localparam logic [DET_BITS-1:0] DET_PEAK    = 3'd2;
   localparam logic [DET_BITS-1:0] DET_TRIGGER = 3'd3;
   localparam logic [DET_BITS-1:0] DET_POST    = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic mul1;
      logic mul2;
      logic decide;
      logic div_step;
      logic finish;
   } afpd_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_update;
   } afpd_status_type;

endpackage

// ===== rtl/afpd_if.sv =====
interface afpd_req_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface afpd_rsp_if #(parameter int SAMPLE_BITS = 16, parameter int FRACTION_BITS = 8);
   logic                                   valid;
   logic                                   ready;
   logic [afpd_pkg::DET_BITS-1:0]          detect_state;
   logic [SAMPLE_BITS-1:0]                 peak_level;
   logic [SAMPLE_BITS+FRACTION_BITS-1:0]   floor_level;
   modport source (output valid, output detect_state, output peak_level,
                   output floor_level, input ready);
   modport sink   (input valid, input detect_state, input peak_level,
                   input floor_level, output ready);
endinterface

interface afpd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [afpd_pkg::CSR_IDX_BITS-1:0]  index;
   logic [afpd_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/adaptive_floor_peak_detector.sv =====
// Adaptive noise-floor peak detector. Each req item carries one magnitude
// sample; each rsp item returns the detection state (below, above, peak,
// trigger, post trigger), the held peak level and the noise floor after the
// sample, in SAMPLE_BITS.FRACTION_BITS fixed point. Items are taken one at a
// time; a sample that updates the floor also passes through the
// one-bit-per-cycle restoring divider that forms the running or exponential
// mean. A result waiting in the output register does not block the next
// sample; it only holds the delivery step of that sample. The csr port is
// always ready; write it only while no item is in flight. Writing the
// preset floor or count also loads the live floor state. Reset restores the
// configuration and detector state registers to their defaults.
module adaptive_floor_peak_detector #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   afpd_req_if.sink      req_bus,
   afpd_rsp_if.source    rsp_bus,
   afpd_csr_if.sink      csr_bus
);

   afpd_pkg::afpd_cmd_type    cmd;
   afpd_pkg::afpd_status_type status;

   assign csr_bus.ready = 1'b1;

   afpd_ctrl #(
      .FLOOR_BITS (SAMPLE_BITS + FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   afpd_dpath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_bus.valid && csr_bus.ready),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .req_sample       (req_bus.sample),
      .rsp_detect_state (rsp_bus.detect_state),
      .rsp_peak_level   (rsp_bus.peak_level),
      .rsp_floor_level  (rsp_bus.floor_level)
   );

`ifndef SYNTHESIS
   // Only one command per cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("controller issued more than one command");

   // An accepted item starts the multiply step next cycle
   a_accept_mul: assert property (@(posedge clock)
      !reset && req_bus.valid && req_bus.ready |=> cmd.mul1)
      else $error("accepted item did not start processing");

   // Finishing an item presents a result
   a_finish_rsp: assert property (@(posedge clock)
      !reset && cmd.finish |=> rsp_bus.valid)
      else $error("finished item not presented");

   // Delivered state codes stay in the defined range
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.detect_state <= afpd_pkg::DET_POST)
      else $error("undefined detection state delivered");
`endif

endmodule

// ===== rtl/afpd_ctrl.sv =====
module afpd_ctrl #(
   parameter int FLOOR_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  afpd_pkg::afpd_status_type status,
   output afpd_pkg::afpd_cmd_type    cmd
);

   localparam int CNT_BITS = (FLOOR_BITS > 1) ? $clog2(FLOOR_BITS) : 1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL1   = 6'b000010,
      ST_MUL2   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one item: accept, multiply, multiply, decide, divide if the floor updates, deliver
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            cnt_in     = CNT_BITS'(FLOOR_BITS - 1);
            state_in   = status.need_update ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/afpd_dpath.sv =====
module afpd_dpath #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  afpd_pkg::afpd_cmd_type                 cmd,
   output afpd_pkg::afpd_status_type              status,
   input  logic                                   csr_write,
   input  logic [afpd_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [afpd_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic [SAMPLE_BITS-1:0]                 req_sample,
   output logic [afpd_pkg::DET_BITS-1:0]          rsp_detect_state,
   output logic [SAMPLE_BITS-1:0]                 rsp_peak_level,
   output logic [SAMPLE_BITS+FRACTION_BITS-1:0]   rsp_floor_level
);

   localparam int FLB      = SAMPLE_BITS + FRACTION_BITS;
   localparam int LB       = afpd_pkg::LEN_BITS;
   localparam int DIV_BITS = LB + 1;
   localparam int PR_BITS  = FLB + afpd_pkg::RISE_BITS;
   localparam int TH_BITS  = PR_BITS - afpd_pkg::RATIO_BITS;
   localparam int FM_BITS  = FLB + LB;
   localparam int NUM_BITS = FLB + DIV_BITS;
   localparam int SH_BITS  = FRACTION_BITS + afpd_pkg::RATIO_BITS;

   // Configuration registers
   logic [afpd_pkg::RISE_BITS-1:0] rise_ff;
   logic [LB-1:0]                  confirm_ff;
   logic [LB-1:0]                  length_ff;
   logic [afpd_pkg::FALL_BITS-1:0] fall_ff;

   // Detector state
   logic [afpd_pkg::DET_BITS-1:0] det_ff, det_in;
   logic [FLB-1:0]                floor_ff, floor_new;
   logic [LB-1:0]                 count_ff;
   logic [SAMPLE_BITS-1:0]        peak_ff, peak_in;
   logic [LB-1:0]                 cc_ff, cc_in;
   logic                          upd_ff;

   // Working registers
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [PR_BITS-1:0]     prod_r_ff;
   logic [FM_BITS-1:0]     prod_fm_ff;
   logic [DIV_BITS-1:0]    dvs_ff;
   logic [PR_BITS-1:0]     thr_fall_ff;
   logic [NUM_BITS-1:0]    num_ff;
   logic [DIV_BITS-1:0]    rem_ff, rem_in;
   logic [FLB-1:0]         quo_ff;

   logic [LB-1:0]       len_eff;
   logic                count_low;
   logic [LB-1:0]       m_val;
   logic [PR_BITS-1:0]  s_scaled;
   logic                above_rise, below_rearm, need_update;
   logic [TH_BITS-1:0]  thr;
   logic [DIV_BITS:0]   trial;
   logic                ge;

   // Averaging weight from the sample count
   assign len_eff   = (length_ff == '0) ? LB'(1) : length_ff;
   assign count_low = count_ff < len_eff;
   assign m_val     = count_low ? count_ff : len_eff - 1'b1;

   // Threshold compares
   assign s_scaled    = PR_BITS'(sample_ff) << SH_BITS;
   assign above_rise  = s_scaled > prod_r_ff;
   assign below_rearm = s_scaled < thr_fall_ff;
   assign thr         = prod_r_ff[PR_BITS-1:afpd_pkg::RATIO_BITS];

   // Next detection state
   always_comb begin
      det_in      = det_ff;
      peak_in     = peak_ff;
      cc_in       = cc_ff;
      need_update = 1'b0;
      case (det_ff)
         afpd_pkg::DET_ABOVE, afpd_pkg::DET_PEAK: begin
            cc_in = (det_ff == afpd_pkg::DET_PEAK) ? '0 : cc_ff;
            if (cc_in != '1) begin
               cc_in = cc_in + 1'b1;
            end
            if (sample_ff > peak_ff) begin
               det_in  = afpd_pkg::DET_PEAK;
               peak_in = sample_ff;
            end else if (cc_in >= confirm_ff) begin
               det_in = afpd_pkg::DET_TRIGGER;
            end else begin
               det_in = afpd_pkg::DET_ABOVE;
            end
         end
         afpd_pkg::DET_TRIGGER, afpd_pkg::DET_POST: begin
            det_in      = below_rearm ? afpd_pkg::DET_BELOW : afpd_pkg::DET_POST;
            need_update = 1'b1;
         end
         default: begin
            if (above_rise) begin
               det_in  = afpd_pkg::DET_PEAK;
               peak_in = sample_ff;
            end else begin
               det_in      = afpd_pkg::DET_BELOW;
               need_update = 1'b1;
            end
         end
      endcase
   end

   assign status.need_update = need_update;

   // One restoring division step
   assign trial  = {rem_ff, quo_ff[FLB-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign rem_in = ge ? DIV_BITS'(trial - {1'b0, dvs_ff}) : DIV_BITS'(trial);

   assign floor_new = upd_ff ? quo_ff : floor_ff;

   // Hold configuration and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff    <= afpd_pkg::RISE_RESET;
         confirm_ff <= afpd_pkg::CONFIRM_RESET;
         length_ff  <= afpd_pkg::AVERAGE_RESET;
         fall_ff    <= afpd_pkg::FALL_RESET;
         det_ff     <= afpd_pkg::DET_BELOW;
         floor_ff   <= '0;
         count_ff   <= '0;
         peak_ff    <= '0;
         cc_ff      <= '0;
         upd_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               afpd_pkg::REG_RISE_RATIO:
                  rise_ff <= csr_data[afpd_pkg::RISE_BITS-1:0];
               afpd_pkg::REG_CONFIRM_LENGTH:
                  confirm_ff <= csr_data[LB-1:0];
               afpd_pkg::REG_AVERAGE_LENGTH:
                  length_ff <= csr_data[LB-1:0];
               afpd_pkg::REG_FALL_RATIO:
                  fall_ff <= csr_data[afpd_pkg::FALL_BITS-1:0];
               afpd_pkg::REG_PRESET_FLOOR:
                  floor_ff <= FLB'(csr_data);
               afpd_pkg::REG_PRESET_COUNT:
                  count_ff <= csr_data[LB-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.decide) begin
            det_ff  <= det_in;
            peak_ff <= peak_in;
            cc_ff   <= cc_in;
            upd_ff  <= need_update;
            if (need_update && count_low) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.finish) begin
            floor_ff <= floor_new;
         end
      end
   end

   // Advance the arithmetic pipeline and divider
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.mul1) begin
         prod_r_ff  <= floor_ff * rise_ff;
         prod_fm_ff <= floor_ff * m_val;
         dvs_ff     <= DIV_BITS'(m_val) + 1'b1;
      end
      if (cmd.mul2) begin
         thr_fall_ff <= thr * fall_ff;
         num_ff      <= NUM_BITS'(prod_fm_ff)
                      + (NUM_BITS'(sample_ff) << FRACTION_BITS)
                      + NUM_BITS'(dvs_ff[DIV_BITS-1:1]);
      end
      if (cmd.decide) begin
         rem_ff <= num_ff[NUM_BITS-1:FLB];
         quo_ff <= num_ff[FLB-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[FLB-2:0], ge};
      end
      if (cmd.finish) begin
         rsp_detect_state <= det_ff;
         rsp_peak_level   <= peak_ff;
         rsp_floor_level  <= floor_new;
      end
   end

endmodule

// ===== sim/tb.sv =====
module tb;

   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 8;
   localparam int FLOOR_W  = SAMPLE_W + FRAC_W;
   localparam int DET_W    = afpd_pkg::DET_BITS;
   localparam int RISE_W   = afpd_pkg::RISE_BITS;
   localparam int LEN_W    = afpd_pkg::LEN_BITS;
   localparam int FALL_W   = afpd_pkg::FALL_BITS;
   localparam int IDX_W    = afpd_pkg::CSR_IDX_BITS;
   localparam int DATA_W   = afpd_pkg::CSR_DATA_BITS;
   localparam int RATIO_W  = afpd_pkg::RATIO_BITS;

   // Spare register slots, writes there must change nothing
   localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [DET_W-1:0]    det;
      logic [SAMPLE_W-1:0] peak;
      logic [FLOOR_W-1:0]  floor_lvl;
   } detection_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                known;
      logic [DET_W-1:0]    det;
      logic [SAMPLE_W-1:0] peak;
      logic [FLOOR_W-1:0]  floor_lvl;
   } script_row_type;

   typedef enum logic [1:0] {GEN_NOISE, GEN_PULSE, GEN_TAIL} gen_mode_type;

   logic clock;
   logic reset;

   afpd_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_if ();
   afpd_rsp_if #(.SAMPLE_BITS(SAMPLE_W), .FRACTION_BITS(FRAC_W)) rsp_if ();
   afpd_csr_if csr_if ();

   adaptive_floor_peak_detector #(
      .SAMPLE_BITS   (SAMPLE_W),
      .FRACTION_BITS (FRAC_W)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Detector model: registers
   logic [RISE_W-1:0] rise_q;
   logic [LEN_W-1:0]  confirm_len_q;
   logic [LEN_W-1:0]  avg_len_q;
   logic [FALL_W-1:0] fall_q;

   // Detector model: state
   logic [DET_W-1:0]    det_q;
   logic [FLOOR_W-1:0]  floor_q;
   logic [LEN_W-1:0]    count_q;
   logic [SAMPLE_W-1:0] peak_q;
   logic [LEN_W-1:0]    confirm_q;

   detection_type expected_detections [$];
   int            mismatches = 0;
   logic          steady = 1'b0;

   // Sample generator state
   gen_mode_type        gen_mode = GEN_NOISE;
   int                  pulse_left = 0;
   int                  tail_left = 0;
   int                  noise_top = 200;
   logic [SAMPLE_W-1:0] pulse_top = '0;

   // Directed opening: a full detect cycle, then extremes and alternating bits
   script_row_type script_rows [22] = '{
      '{16'd0,     1'b1, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd100,   1'b1, afpd_pkg::DET_PEAK,    16'd100, 24'd0},
      '{16'd50,    1'b1, afpd_pkg::DET_ABOVE,   16'd100, 24'd0},
      '{16'd50,    1'b1, afpd_pkg::DET_ABOVE,   16'd100, 24'd0},
      '{16'd50,    1'b1, afpd_pkg::DET_ABOVE,   16'd100, 24'd0},
      '{16'd50,    1'b1, afpd_pkg::DET_TRIGGER, 16'd100, 24'd0},
      '{16'd0,     1'b1, afpd_pkg::DET_POST,    16'd100, 24'd0},
      '{16'hFFFF,  1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd0,     1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'h5555,  1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'hAAAA,  1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd30000, 1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd50000, 1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd50000, 1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'hFFFF,  1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd1,     1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd1,     1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd1,     1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd1,     1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'hFFFF,  1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'hFFFF,  1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0},
      '{16'd0,     1'b0, afpd_pkg::DET_BELOW,   16'd0,   24'd0}
   };

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Fold one sample into the noise floor: running mean, then exponential
   function automatic void mix_floor(input logic [SAMPLE_W-1:0] s);
      logic [63:0] len;
      logic [63:0] m;
      logic [63:0] num;
      len = (avg_len_q == '0) ? 64'd1 : 64'(avg_len_q);
      if (64'(count_q) < len) begin
         m = 64'(count_q);
         count_q = count_q + 1'b1;
      end else begin
         m = len - 1;
      end
      num = 64'(floor_q) * m + (64'(s) << FRAC_W) + ((m + 1) >> 1);
      floor_q = FLOOR_W'(num / (m + 1));
   endfunction

   // Advance the detector by one sample and return the result it reports
   function automatic detection_type detector_step(input logic [SAMPLE_W-1:0] s);
      logic [63:0]   scaled;
      logic [63:0]   thr;
      detection_type r;
      scaled = 64'(s) << (FRAC_W + RATIO_W);
      case (det_q)
         afpd_pkg::DET_PEAK, afpd_pkg::DET_ABOVE: begin
            if (det_q == afpd_pkg::DET_PEAK)
               confirm_q = '0;
            det_q = afpd_pkg::DET_ABOVE;
            if (confirm_q != 16'hFFFF)
               confirm_q = confirm_q + 1'b1;
            if (s > peak_q) begin
               det_q  = afpd_pkg::DET_PEAK;
               peak_q = s;
            end else if (confirm_q >= confirm_len_q) begin
               det_q = afpd_pkg::DET_TRIGGER;
            end
         end
         afpd_pkg::DET_TRIGGER, afpd_pkg::DET_POST: begin
            // rearm threshold is truncated to the floor's fraction before scaling
            thr   = (64'(floor_q) * 64'(rise_q)) >> RATIO_W;
            det_q = (scaled < thr * 64'(fall_q)) ? afpd_pkg::DET_BELOW
                                                 : afpd_pkg::DET_POST;
            mix_floor(s);
         end
         default: begin
            if (scaled > 64'(floor_q) * 64'(rise_q)) begin
               det_q  = afpd_pkg::DET_PEAK;
               peak_q = s;
            end else begin
               det_q = afpd_pkg::DET_BELOW;
               mix_floor(s);
            end
         end
      endcase
      r.det       = det_q;
      r.peak      = peak_q;
      r.floor_lvl = floor_q;
      return r;
   endfunction

   function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] d);
      case (idx)
         afpd_pkg::REG_RISE_RATIO:     rise_q        = d[RISE_W-1:0];
         afpd_pkg::REG_CONFIRM_LENGTH: confirm_len_q = d[LEN_W-1:0];
         afpd_pkg::REG_AVERAGE_LENGTH: avg_len_q     = d[LEN_W-1:0];
         afpd_pkg::REG_FALL_RATIO:     fall_q        = d[FALL_W-1:0];
         afpd_pkg::REG_PRESET_FLOOR:   floor_q       = d[FLOOR_W-1:0];
         afpd_pkg::REG_PRESET_COUNT:   count_q       = d[LEN_W-1:0];
         default: ;
      endcase
   endfunction

   // Pick the next sample: noise up to noise_top, pulses that cross the threshold
   // and outlast a confirm window of up to 16, low tails, rare random and extremes
   function automatic logic [SAMPLE_W-1:0] next_sample();
      logic [63:0]         thr;
      logic [63:0]         top;
      logic [SAMPLE_W-1:0] s;
      int                  roll;
      thr = ((64'(floor_q) * 64'(rise_q)) >> (FRAC_W + RATIO_W)) + 1;
      if (thr > 64'hFFFF)
         thr = 64'hFFFF;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         s = SAMPLE_W'($urandom());
      end else if (roll == 3) begin
         s = '0;
      end else if (roll == 4) begin
         s = '1;
      end else begin
         case (gen_mode)
            GEN_NOISE: begin
               s = SAMPLE_W'($urandom_range(0, noise_top));
               if ($urandom_range(0, 99) < 6) begin
                  gen_mode   = GEN_PULSE;
                  pulse_left = $urandom_range(1, 8) +
                               ((confirm_len_q < 16) ? int'(confirm_len_q) : 16);
                  top = thr + $urandom_range(0, int'(thr));
                  pulse_top = (top > 64'hFFFF) ? 16'hFFFF : SAMPLE_W'(top);
               end
            end
            GEN_PULSE: begin
               if (det_q == afpd_pkg::DET_BELOW) begin
                  s = pulse_top;
               end else if ($urandom_range(0, 99) < 15 && pulse_top != 16'hFFFF) begin
                  // climb a little so the peak moves
                  top = 64'(pulse_top) + $urandom_range(1, 64);
                  pulse_top = (top > 64'hFFFF) ? 16'hFFFF : SAMPLE_W'(top);
                  s = pulse_top;
               end else begin
                  s = SAMPLE_W'($urandom_range(pulse_top / 2, pulse_top));
               end
               pulse_left--;
               if (pulse_left <= 0) begin
                  gen_mode  = GEN_TAIL;
                  tail_left = $urandom_range(1, 6);
               end
            end
            default: begin
               s = SAMPLE_W'($urandom_range(0, noise_top / 4));
               tail_left--;
               if (tail_left <= 0)
                  gen_mode = GEN_NOISE;
            end
         endcase
      end
      return s;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("mismatch @%0t: %s", $time, msg);
   endtask

   // Hand one sample to the block and queue what it should report
   task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic known,
                              input detection_type typed_result);
      detection_type want;
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 36)) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      do @(posedge clock); while (!req_if.ready);
      want = detector_step(s);
      if (known)
         want = typed_result;
      expected_detections.push_back(want);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] d);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= d;
      do @(posedge clock); while (!csr_if.ready);
      apply_reg(idx, d);
   endtask

   // Load one register setting; fixed corners first, random after
   task automatic program_phase(input int phase);
      logic [RISE_W-1:0]  rise;
      logic [LEN_W-1:0]   conf;
      logic [LEN_W-1:0]   avg;
      logic [FALL_W-1:0]  fall;
      logic [FLOOR_W-1:0] pre_floor;
      logic [LEN_W-1:0]   pre_count;
      case (phase)
         1: begin
            rise = 12'd257;  conf = 16'd0;     avg = 16'd0;
            fall = 8'd255;   pre_floor = '0;   pre_count = '0;
         end
         2: begin
            rise = 12'hFFF;  conf = 16'hFFFF;  avg = 16'hFFFF;
            fall = 8'd0;     pre_floor = '1;   pre_count = 16'hFFFF;
         end
         3: begin
            rise = 12'd0;    conf = 16'd1;     avg = 16'd1;
            fall = 8'd128;   pre_floor = 24'h000100; pre_count = '0;
         end
         4: begin
            rise = 12'd256;  conf = 16'd2;     avg = 16'd16;
            fall = 8'd200;   pre_floor = '0;   pre_count = 16'd15;
         end
         default: begin
            rise = ($urandom_range(0, 9) == 0) ? RISE_W'($urandom_range(0, 4095))
                                               : RISE_W'($urandom_range(257, 1024));
            conf = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom())
                                               : LEN_W'($urandom_range(0, 12));
            avg  = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom())
                                               : LEN_W'($urandom_range(1, 300));
            fall = FALL_W'($urandom());
            pre_floor = FLOOR_W'($urandom_range(0, 24'h0C0000));
            pre_count = LEN_W'($urandom_range(0, avg));
         end
      endcase
      // upper data bits carry junk for the narrow registers
      write_reg(afpd_pkg::REG_RISE_RATIO,     {12'($urandom()), rise});
      write_reg(afpd_pkg::REG_CONFIRM_LENGTH, {8'($urandom()), conf});
      write_reg(afpd_pkg::REG_AVERAGE_LENGTH, {8'($urandom()), avg});
      write_reg(afpd_pkg::REG_FALL_RATIO,     {16'($urandom()), fall});
      write_reg(afpd_pkg::REG_PRESET_FLOOR,   pre_floor);
      write_reg(afpd_pkg::REG_PRESET_COUNT,   {8'($urandom()), pre_count});
      if (phase == 1 || phase == 3) begin
         write_reg(REG_SPARE_6, DATA_W'($urandom()));
         write_reg(REG_SPARE_7, DATA_W'($urandom()));
      end
      csr_if.valid <= 1'b0;
   endtask

   // Result side backpressure
   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 7);
   end

   // Compare each delivered result with the oldest expectation
   always @(posedge clock) begin
      detection_type got;
      detection_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.det       = rsp_if.detect_state;
         got.peak      = rsp_if.peak_level;
         got.floor_lvl = rsp_if.floor_level;
         if (expected_detections.size() == 0) begin
            note_mismatch($sformatf("result with nothing pending: det %0d peak %0d floor %0h",
                                    got.det, got.peak, got.floor_lvl));
         end else begin
            want = expected_detections.pop_front();
            if (got.det !== want.det || got.peak !== want.peak ||
                got.floor_lvl !== want.floor_lvl)
               note_mismatch($sformatf("det %0d/%0d peak %0d/%0d floor %0h/%0h (got/want)",
                                       got.det, want.det, got.peak, want.peak,
                                       got.floor_lvl, want.floor_lvl));
         end
      end
   end

   // Stimulus
   initial begin
      detection_type typed_result;
      reset         = 1'b1;
      req_if.valid  <= 1'b0;
      req_if.sample <= '0;
      csr_if.valid  <= 1'b0;
      csr_if.index  <= '0;
      csr_if.data   <= '0;

      rise_q        = afpd_pkg::RISE_RESET;
      confirm_len_q = afpd_pkg::CONFIRM_RESET;
      avg_len_q     = afpd_pkg::AVERAGE_RESET;
      fall_q        = afpd_pkg::FALL_RESET;
      det_q         = afpd_pkg::DET_BELOW;
      floor_q       = '0;
      count_q       = '0;
      peak_q        = '0;
      confirm_q     = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows under reset settings
      foreach (script_rows[i]) begin
         typed_result.det       = script_rows[i].det;
         typed_result.peak      = script_rows[i].peak;
         typed_result.floor_lvl = script_rows[i].floor_lvl;
         push_sample(script_rows[i].sample, script_rows[i].known, typed_result);
      end

      typed_result = '0;
      for (int phase = 1; phase <= 9; phase++) begin
         // drain before touching registers
         req_if.valid <= 1'b0;
         while (expected_detections.size() != 0) @(posedge clock);
         program_phase(phase);
         steady    = (phase == 5 || phase == 6);
         noise_top = $urandom_range(4, 3000);
         gen_mode  = GEN_NOISE;
         for (int n = 0; n < 120; n++)
            push_sample(next_sample(), 1'b0, typed_result);
      end
      req_if.valid <= 1'b0;

      while (expected_detections.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== adaptive_floor_peak_detector.f =====
rtl/afpd_pkg.sv
rtl/afpd_if.sv
rtl/afpd_ctrl.sv
rtl/afpd_dpath.sv
rtl/adaptive_floor_peak_detector.sv
sim/tb.sv
